@@ design/iir_tdf2_pkg.sv @@
// Package for the transposed direct form II IIR filter core.
// Holds register indexes, the reset shift value, the controller state type
// and the command/status structs. It depends on nothing else.
package iir_tdf2_pkg;

	localparam int SAMPLE_W = 16;
	localparam int COEFF_W  = 16;
	localparam int OUT_W    = 32;
	localparam int SHIFT_W  = 4;
	localparam int INDEX_W  = 3;

	// Configuration register indexes.
	localparam logic [INDEX_W-1:0] REG_B0   = 3'd0;
	localparam logic [INDEX_W-1:0] REG_A1   = 3'd4;
	localparam logic [INDEX_W-1:0] REG_FRAC = 3'd7;

	localparam logic [SHIFT_W-1:0] FRAC_RESET = 4'd14;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MULB0,
		ST_CALCY,
		ST_LOOP0,
		ST_LOOP,
		ST_ACC,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic ld_x;
		logic mul_b0;
		logic calc_y;
		logic mul_step;
		logic acc_step;
		logic ld_out;
	} cmd_t;

	typedef struct packed {
		logic mul_last;
	} sts_t;

endpackage

@@ design/iir_tdf2_ctrl.sv @@
// Sequencer of the IIR filter core: steps the datapath through one sample
// and owns the input and output handshakes. Depends on iir_tdf2_pkg.
module iir_tdf2_ctrl
	import iir_tdf2_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	output logic out_valid,
	input  logic out_stall,
	output cmd_t cmd,
	input  sts_t sts
);

	state_t state_q, state_nxt;
	logic   out_valid_q;
	logic   out_free;

	// The output register may be loaded when empty or when its beat leaves now.
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.ld_out)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		in_stall  = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.ld_x  = 1'b1;
					state_nxt = ST_MULB0;
				end
			end
			ST_MULB0: begin
				cmd.mul_b0 = 1'b1;
				state_nxt  = ST_CALCY;
			end
			ST_CALCY: begin
				cmd.calc_y = 1'b1;
				state_nxt  = ST_LOOP0;
			end
			ST_LOOP0: begin
				cmd.mul_step = 1'b1;
				state_nxt    = sts.mul_last ? ST_ACC : ST_LOOP;
			end
			ST_LOOP: begin
				// Products of one delay term are formed while the previous
				// term is accumulated.
				cmd.mul_step = 1'b1;
				cmd.acc_step = 1'b1;
				state_nxt    = sts.mul_last ? ST_ACC : ST_LOOP;
			end
			ST_ACC: begin
				cmd.acc_step = 1'b1;
				if (out_free) begin
					cmd.ld_out = 1'b1;
					state_nxt  = ST_IDLE;
				end else begin
					state_nxt = ST_OUT;
				end
			end
			ST_OUT: begin
				if (out_free) begin
					cmd.ld_out = 1'b1;
					state_nxt  = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

endmodule

@@ design/iir_tdf2_dpath.sv @@
// Datapath of the IIR filter core: coefficient registers, the shared
// multiplier pair, the delay terms and the output register.
// Depends on iir_tdf2_pkg.
module iir_tdf2_dpath
	import iir_tdf2_pkg::*;
#(
	parameter int TAPS = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [INDEX_W-1:0]         cfg_index,
	input  logic [COEFF_W-1:0]         cfg_data,
	input  logic signed [SAMPLE_W-1:0] sample_in,
	output logic signed [OUT_W-1:0]    sample_out,
	input  cmd_t                       cmd,
	output sts_t                       sts
);

	localparam int NDELAY = TAPS - 1;
	localparam int KW     = (NDELAY > 1) ? $clog2(NDELAY) : 1;
	localparam int CW     = $clog2(TAPS);
	localparam int PA_W   = COEFF_W + OUT_W;
	localparam int DIFF_W = PA_W + 1;

	logic signed [COEFF_W-1:0]  b_q [0:TAPS-1];
	logic signed [COEFF_W-1:0]  a_q [1:TAPS-1];
	logic [SHIFT_W-1:0]         frac_q;

	logic signed [SAMPLE_W-1:0] x_q;
	logic signed [OUT_W-1:0]    y_q;
	logic signed [OUT_W-1:0]    out_q;
	logic signed [OUT_W-1:0]    v_q [0:NDELAY-1];
	logic [KW-1:0]              mul_k_q;
	logic [KW-1:0]              acc_k_q;

	logic signed [OUT_W-1:0]    pb_s1;
	logic signed [PA_W-1:0]     pa_s1;

	logic [CW-1:0]              coeff_idx;
	logic signed [COEFF_W-1:0]  b_sel;
	logic signed [COEFF_W-1:0]  a_sel;
	logic signed [OUT_W-1:0]    bx;
	logic signed [PA_W-1:0]     ay;
	logic signed [OUT_W-1:0]    pb_shifted;
	logic signed [DIFF_W-1:0]   diff;
	logic signed [DIFF_W-1:0]   diff_shifted;
	logic                       acc_last;
	logic [KW-1:0]              next_k;
	logic signed [OUT_W-1:0]    carry_in;

	assign coeff_idx = CW'(mul_k_q) + CW'(1);
	assign b_sel     = cmd.mul_b0 ? b_q[0] : b_q[coeff_idx];
	assign a_sel     = a_q[coeff_idx];
	assign bx        = b_sel * x_q;
	assign ay        = a_sel * y_q;

	assign sts.mul_last = (mul_k_q == KW'(TAPS - 2));

	// The scaled delay term has zero fraction bits, so it passes the shift
	// unchanged and is added after it.
	assign pb_shifted   = pb_s1 >>> frac_q;
	assign diff         = DIFF_W'(pb_s1) - DIFF_W'(pa_s1);
	assign diff_shifted = diff >>> frac_q;

	assign acc_last = (acc_k_q == KW'(TAPS - 2));
	assign next_k   = acc_last ? acc_k_q : KW'(acc_k_q + KW'(1));
	assign carry_in = acc_last ? '0 : v_q[next_k];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TAPS; i++)
				b_q[i] <= '0;
			for (int i = 1; i < TAPS; i++)
				a_q[i] <= '0;
			frac_q <= FRAC_RESET;
		end else if (cfg_we) begin
			for (int i = 0; i < TAPS; i++)
				if (cfg_index == REG_B0 + INDEX_W'(i))
					b_q[i] <= cfg_data;
			for (int i = 1; i < TAPS; i++)
				if (cfg_index == REG_A1 + INDEX_W'(i - 1))
					a_q[i] <= cfg_data;
			if (cfg_index == REG_FRAC)
				frac_q <= cfg_data[SHIFT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NDELAY; i++)
				v_q[i] <= '0;
			mul_k_q <= '0;
			acc_k_q <= '0;
		end else begin
			if (cmd.calc_y) begin
				mul_k_q <= '0;
				acc_k_q <= '0;
			end else begin
				// The term count holds at the last term, so the coefficient
				// select never points past the register file.
				if (cmd.mul_step && !sts.mul_last)
					mul_k_q <= KW'(mul_k_q + KW'(1));
				if (cmd.acc_step)
					acc_k_q <= KW'(acc_k_q + KW'(1));
			end
			// Terms are rewritten in ascending order, so the next term read
			// here still holds its value from before this sample.
			if (cmd.acc_step)
				v_q[acc_k_q] <= carry_in + diff_shifted[OUT_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_x)
			x_q <= sample_in;
		if (cmd.mul_b0 || cmd.mul_step)
			pb_s1 <= bx;
		if (cmd.mul_step)
			pa_s1 <= ay;
		if (cmd.calc_y)
			y_q <= v_q[0] + pb_shifted;
		if (cmd.ld_out)
			out_q <= y_q;
	end

	assign sample_out = out_q;

endmodule

@@ design/iir_tdf2_core.sv @@
// Top level of the transposed direct form II fixed-point IIR filter.
// Depends on iir_tdf2_pkg, iir_tdf2_ctrl and iir_tdf2_dpath.
//
// Each accepted 16-bit sample gives one 32-bit filtered sample, wrapped to
// 32 bits with floor shifts by frac_q. The core takes no new sample until it
// is through with the last one: one 16x16 and one 16x32 multiplier are
// shared and stepped once per delay term. The output is registered, so the
// next sample is taken while a finished result still waits to leave.
// Write the coefficient registers only while the core is idle.
module iir_transposed_df2_fixed_core
	import iir_tdf2_pkg::*;
#(
	parameter int TAPS = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [INDEX_W-1:0]         cfg_index,
	input  logic [COEFF_W-1:0]         cfg_data,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic signed [SAMPLE_W-1:0] sample_in,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic signed [OUT_W-1:0]    sample_out
);

	cmd_t cmd;
	sts_t sts;

	iir_tdf2_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	iir_tdf2_dpath #(
		.TAPS (TAPS)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.sample_in  (sample_in),
		.sample_out (sample_out),
		.cmd        (cmd),
		.sts        (sts)
	);

endmodule
